>>> hw/rtl/smp_pkg.sv
// Constants, stage payload type and SHA-256 helper functions for the midstate precalc block.
package smp_pkg;

   localparam int NUM_SLOTS = 57;
   localparam int SLOT_W    = 6;
   localparam int NUM_STG   = 5;

   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [SLOT_W-1:0] SLOT_COUNT = SLOT_W'(NUM_SLOTS);

   // Round constants as used by this precalc, the first 18 standard SHA-256 values.
   localparam logic [31:0] KC [18] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786
   };

   localparam logic [31:0] D_ADD       = 32'hb956c25b;
   localparam logic [31:0] W17_ADD     = 32'h01100000;
   localparam logic [31:0] PV4_ADD     = 32'he9b5dba5;
   localparam logic [31:0] W31_ADD     = 32'h00000280;
   localparam logic [31:0] W19_ADD     = 32'h11002000;
   localparam logic [31:0] A_ADD_0     = 32'h98c7e2a2;
   localparam logic [31:0] A_ADD_1     = 32'hfc08884d;
   localparam logic [31:0] B_ADD       = 32'h90bb1e3c;
   localparam logic [31:0] C_ADD       = 32'h50c6645b;
   localparam logic [31:0] DW_ADD      = 32'h3ac42e24;

   typedef struct packed {
      logic [31:0]       wa, wb, wc, wd, we, wf, wg, wh;  // working state
      logic [7:0][31:0]  sw;                              // input state
      logic [2:0][31:0]  dw;                              // data words
      logic [31:0]       w16, w17;
      logic [31:0]       p28, p29, p30, p31;
      logic [31:0]       pv4, t1;
   } stage_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] chf(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
      return g ^ (e & (f ^ g));
   endfunction

   function automatic logic [31:0] majf(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
      return (a & b) | (c & (a | b));
   endfunction

endpackage

>>> hw/rtl/sha256_midstate_precalc.sv
// Top level: midstate precalc pipeline and 57-word output shift bank.
//
//   channel | dir | handshake            | word
//   req     | in  | req_valid/req_stall  | state_word_0..7, data_word_0..2
//   rsp     | out | rsp_valid/rsp_stall  | slot, value, last
//
// Stage 0 takes the req, stages 1-3 do rounds 0-2, stage 4 forms pv4/t1 for the bank.
// The output bank gives one rsp word a cycle while rsp_stall is low, 57 words per item.
// The bank reloads in the cycle its last word leaves, so runs go out back to back.
// Reset (synchronous) clears stage valids, bank count and slot index; data regs keep junk.
// rsp_stall holds the bank; the five stages fill up behind it before req_stall rises.
module sha256_midstate_precalc (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_state_word_0,
   input  logic [31:0] req_state_word_1,
   input  logic [31:0] req_state_word_2,
   input  logic [31:0] req_state_word_3,
   input  logic [31:0] req_state_word_4,
   input  logic [31:0] req_state_word_5,
   input  logic [31:0] req_state_word_6,
   input  logic [31:0] req_state_word_7,
   input  logic [31:0] req_data_word_0,
   input  logic [31:0] req_data_word_1,
   input  logic [31:0] req_data_word_2,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [smp_pkg::SLOT_W-1:0] rsp_slot,
   output logic [31:0] rsp_value,
   output logic        rsp_last
);
   import smp_pkg::*;

   stage_type             st_ff  [NUM_STG];
   stage_type             st_in  [NUM_STG];
   logic [NUM_STG-1:0]    vld_ff;
   logic [NUM_STG-1:0]    adv;

   logic [31:0]           rnd_t1, rnd_t2, rnd_t3;
   logic [31:0]           pv0, pv4_t1;

   logic [31:0]           bank_ff [NUM_SLOTS];
   logic [31:0]           bank_in [NUM_SLOTS];
   logic [SLOT_W-1:0]     cnt_ff, cnt_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  bank_free, bank_load, rsp_take;

   // ---------------- flow control ----------------
   assign rsp_take  = rsp_valid & ~rsp_stall;
   assign bank_free = (cnt_ff == '0) | ((cnt_ff == SLOT_W'(1)) & ~rsp_stall);
   assign bank_load = vld_ff[NUM_STG-1] & bank_free;

   always_comb begin
      adv[NUM_STG-1] = ~vld_ff[NUM_STG-1] | bank_load;
      for (int i = NUM_STG - 2; i >= 0; i--) begin
         adv[i] = ~vld_ff[i] | adv[i+1];
      end
   end

   assign req_stall = ~adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STG; i++) begin
         if (adv[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // ---------------- stage logic ----------------
   always_comb begin
      st_in[0]       = st_ff[0];
      st_in[0].sw[0] = req_state_word_0;
      st_in[0].sw[1] = req_state_word_1;
      st_in[0].sw[2] = req_state_word_2;
      st_in[0].sw[3] = req_state_word_3;
      st_in[0].sw[4] = req_state_word_4;
      st_in[0].sw[5] = req_state_word_5;
      st_in[0].sw[6] = req_state_word_6;
      st_in[0].sw[7] = req_state_word_7;
      st_in[0].dw[0] = req_data_word_0;
      st_in[0].dw[1] = req_data_word_1;
      st_in[0].dw[2] = req_data_word_2;
      st_in[0].wa    = req_state_word_0;
      st_in[0].wb    = req_state_word_1;
      st_in[0].wc    = req_state_word_2;
      st_in[0].wd    = req_state_word_3;
      st_in[0].we    = req_state_word_4;
      st_in[0].wf    = req_state_word_5;
      st_in[0].wg    = req_state_word_6;
      st_in[0].wh    = req_state_word_7;
   end

   // round 0 updates d and h; message words 16 and 17 in parallel
   assign rnd_t1 = st_ff[0].wh + big_s1(st_ff[0].we)
                 + chf(st_ff[0].we, st_ff[0].wf, st_ff[0].wg) + KC[0] + st_ff[0].dw[0];

   always_comb begin
      st_in[1]     = st_ff[0];
      st_in[1].wd  = st_ff[0].wd + rnd_t1;
      st_in[1].wh  = rnd_t1 + big_s0(st_ff[0].wa)
                   + majf(st_ff[0].wa, st_ff[0].wb, st_ff[0].wc);
      st_in[1].w16 = st_ff[0].dw[0] + small_s0(st_ff[0].dw[1]);
      st_in[1].w17 = st_ff[0].dw[1] + small_s0(st_ff[0].dw[2]) + W17_ADD;
   end

   // round 1 updates c and g; schedule partials from w16/w17
   assign rnd_t2 = st_ff[1].wg + big_s1(st_ff[1].wd)
                 + chf(st_ff[1].wd, st_ff[1].we, st_ff[1].wf) + KC[1] + st_ff[1].dw[1];

   always_comb begin
      st_in[2]     = st_ff[1];
      st_in[2].wc  = st_ff[1].wc + rnd_t2;
      st_in[2].wg  = rnd_t2 + big_s0(st_ff[1].wh)
                   + majf(st_ff[1].wh, st_ff[1].wa, st_ff[1].wb);
      st_in[2].p28 = W31_ADD + small_s0(st_ff[1].w16);
      st_in[2].p29 = st_ff[1].w16 + small_s0(st_ff[1].w17);
      st_in[2].p30 = st_ff[1].dw[2] + small_s1(st_ff[1].w16);
      st_in[2].p31 = W19_ADD + small_s1(st_ff[1].w17);
   end

   // round 2 updates b and f
   assign rnd_t3 = st_ff[2].wf + big_s1(st_ff[2].wc)
                 + chf(st_ff[2].wc, st_ff[2].wd, st_ff[2].we) + KC[2] + st_ff[2].dw[2];

   always_comb begin
      st_in[3]    = st_ff[2];
      st_in[3].wb = st_ff[2].wb + rnd_t3;
      st_in[3].wf = rnd_t3 + big_s0(st_ff[2].wg)
                  + majf(st_ff[2].wg, st_ff[2].wh, st_ff[2].wa);
   end

   always_comb begin
      st_in[4]     = st_ff[3];
      st_in[4].pv4 = st_ff[3].sw[4] + big_s1(st_ff[3].wb)
                   + chf(st_ff[3].wb, st_ff[3].wc, st_ff[3].wd) + PV4_ADD;
      st_in[4].t1  = big_s0(st_ff[3].wf) + majf(st_ff[3].wf, st_ff[3].wg, st_ff[3].wh);
   end

   // ---------------- output bank ----------------
   assign pv0    = st_ff[4].pv4 + st_ff[4].sw[0];
   assign pv4_t1 = st_ff[4].pv4 + st_ff[4].t1;

   always_comb begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
         bank_in[j] = bank_ff[j];
      end
      if (bank_load) begin
         bank_in[0]  = st_ff[4].wa;
         bank_in[1]  = st_ff[4].wb;
         bank_in[2]  = st_ff[4].wc;
         bank_in[3]  = st_ff[4].wd;
         bank_in[4]  = st_ff[4].wd + D_ADD;
         bank_in[5]  = st_ff[4].we;
         bank_in[6]  = st_ff[4].wf;
         bank_in[7]  = st_ff[4].wg;
         bank_in[8]  = st_ff[4].wh;
         for (int j = 0; j < 8; j++) begin
            bank_in[9+j] = st_ff[4].sw[j];
         end
         bank_in[17] = st_ff[4].dw[0];
         bank_in[18] = st_ff[4].dw[1];
         bank_in[19] = st_ff[4].dw[2];
         bank_in[20] = st_ff[4].w16;
         bank_in[21] = st_ff[4].w16;
         bank_in[22] = st_ff[4].w17;
         bank_in[23] = st_ff[4].w17;
         bank_in[24] = st_ff[4].pv4;
         bank_in[25] = st_ff[4].pv4;
         bank_in[26] = st_ff[4].t1;
         bank_in[27] = st_ff[4].t1;
         bank_in[28] = pv4_t1;
         bank_in[29] = pv0;
         bank_in[30] = st_ff[4].p28;
         bank_in[31] = st_ff[4].p29;
         bank_in[32] = st_ff[4].p30;
         bank_in[33] = st_ff[4].p31;
         bank_in[34] = st_ff[4].dw[2];
         bank_in[35] = st_ff[4].p30;
         bank_in[36] = st_ff[4].p31;
         bank_in[37] = st_ff[4].p30;
         bank_in[38] = st_ff[4].p31;
         bank_in[39] = st_ff[4].p28;
         bank_in[40] = st_ff[4].p29;
         bank_in[41] = pv4_t1;
         bank_in[42] = st_ff[4].sw[0] - st_ff[4].t1;
         bank_in[43] = st_ff[4].wc + KC[5];
         bank_in[44] = st_ff[4].wb + KC[6];
         bank_in[45] = st_ff[4].pv4 + st_ff[4].sw[0] + KC[7];
         bank_in[46] = st_ff[4].w16 + KC[16];
         bank_in[47] = st_ff[4].w17 + KC[17];
         bank_in[48] = st_ff[4].sw[0] + A_ADD_0;
         bank_in[49] = st_ff[4].sw[0] + A_ADD_1;
         bank_in[50] = st_ff[4].sw[1] + B_ADD;
         bank_in[51] = st_ff[4].sw[2] + C_ADD;
         bank_in[52] = st_ff[4].sw[3] + DW_ADD;
         bank_in[53] = st_ff[4].sw[4] + KC[4];
         bank_in[54] = st_ff[4].sw[5] + KC[5];
         bank_in[55] = st_ff[4].sw[6] + KC[6];
         bank_in[56] = st_ff[4].sw[7] + KC[7];
      end else if (rsp_take) begin
         for (int j = 0; j < NUM_SLOTS - 1; j++) begin
            bank_in[j] = bank_ff[j+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
         bank_ff[j] <= bank_in[j];
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      slot_in = slot_ff;
      if (bank_load) begin
         cnt_in  = SLOT_COUNT;
         slot_in = '0;
      end else if (rsp_take) begin
         cnt_in  = cnt_ff - SLOT_W'(1);
         slot_in = slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         slot_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         slot_ff <= slot_in;
      end
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_slot  = slot_ff;
   assign rsp_value = bank_ff[0];
   assign rsp_last  = (slot_ff == LAST_SLOT);

   // ---------------- assertions ----------------
   a_cnt_slot_sum: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (SLOT_W'(cnt_ff + slot_ff) == SLOT_COUNT))
      else $error("bank count and slot index disagree");

   a_slot_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last) |=> (rsp_valid && (rsp_slot == $past(rsp_slot) + SLOT_W'(1))))
      else $error("word run broke before its last slot");

   a_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last) |=> (!rsp_valid || (rsp_slot == '0)))
      else $error("new run does not start at slot zero");

   a_req_to_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted word missing from first stage");

endmodule
